@@ hw/rtl/ils_pkg.sv @@
// Shared widths, request codes and status codes for the indexed list store.
package ils_pkg;

  localparam int REQ_W = 3;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_READ      = 3'd0,
    REQ_INS_FRONT = 3'd1,
    REQ_INS_BACK  = 3'd2,
    REQ_INS_POS   = 3'd3,
    REQ_DELETE    = 3'd4
  } req_t;

  typedef logic [ST_W-1:0] status_t;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

@@ hw/rtl/indexed_list_store.sv @@
// Top level of the indexed list store: request sequencer, entry RAM and result register.
//
// The block keeps an ordered list of up to DEPTH signed 32-bit values and a
// count of entries. A request arrives as one transfer on the s_ channel and
// yields exactly one result transfer on the m_ channel.
// Requests are read, insert at front, insert at back, insert before a
// position and delete at a position. The entries live in a single RAM with
// one write and one registered read port, and a single address stepper
// moves entries one cell per cycle when an insert or delete opens or closes
// a gap.
// A read steps through S_READ, S_CAPTURE and S_FINISH; an insert or delete
// runs the stepper in S_SHIFT, an insert then writes its value in S_PUT,
// and both finish in S_FINISH. A request with a bad position, an unused
// code or an insert into a full store goes straight to S_FINISH. s_tready
// rises with m_tvalid, so the next request can be accepted while the
// result is offered.
// The result waits in an output register; if the receiver stalls, the block
// holds it and the next request is finished only once it is taken.
// Reset empties the list at once; no clearing pass is needed since only
// entries below the count are ever read.
module indexed_list_store #(
  parameter int DEPTH = 64,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int IN_TW = ((ils_pkg::REQ_W + CW + ils_pkg::VAL_W + 7) / 8) * 8,
  localparam int OUT_TW = ((ils_pkg::VAL_W + ils_pkg::ST_W + CW + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_TW-1:0]  s_tdata,  // req_type, position, value_in
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_TW-1:0] m_tdata   // read_value, status, entry_count
);

  import ils_pkg::*;

  localparam int AW = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CAPTURE,
    S_SHIFT,
    S_PUT,
    S_FINISH
  } state_t;

  state_t                 state;
  logic [CW-1:0]          count;
  logic                   ins;
  logic [AW-1:0]          ipos;
  logic [VAL_W-1:0]       val_r;
  logic [AW-1:0]          src;
  logic [CW-1:0]          left;
  logic                   pend;
  logic [AW-1:0]          pend_dst;
  logic [VAL_W-1:0]       res_val;
  status_t                res_st;

  logic [REQ_W-1:0]       req_in;
  logic [CW-1:0]          pos_in;
  logic [VAL_W-1:0]       val_in;
  logic [CW-1:0]          ip;
  logic                   accept;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [VAL_W-1:0]       ram_wdata;
  logic [VAL_W-1:0]       ram_rdata;
  logic [AW-1:0]          src_inc;
  logic [AW-1:0]          src_dec;

  assign req_in = s_tdata[REQ_W-1:0];
  assign pos_in = s_tdata[REQ_W+CW-1:REQ_W];
  assign val_in = s_tdata[REQ_W+CW+VAL_W-1:REQ_W+CW];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign src_inc = src + AW'(1);
  assign src_dec = src - AW'(1);

  always_comb begin
    unique case (req_t'(req_in))
      REQ_INS_FRONT: ip = '0;
      REQ_INS_BACK:  ip = count;
      default:       ip = pos_in;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_dst;
    ram_wdata = ram_rdata;
    if (state == S_SHIFT) begin
      ram_we = pend;
    end else if (state == S_PUT) begin
      ram_we    = 1'b1;
      ram_waddr = ipos;
      ram_wdata = val_r;
    end
  end

  ils_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(src),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_FINISH) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            val_r <= val_in;
            pend  <= 1'b0;
            unique case (req_t'(req_in))
              REQ_READ: begin
                if (pos_in < count) begin
                  src    <= pos_in[AW-1:0];
                  res_st <= ST_DONE;
                  state  <= S_READ;
                end else begin
                  res_val <= '1;
                  res_st  <= ST_RANGE;
                  state   <= S_FINISH;
                end
              end
              REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_POS: begin
                res_val <= '0;
                if (ip > count) begin
                  res_st <= ST_RANGE;
                  state  <= S_FINISH;
                end else if (count == CW'(DEPTH)) begin
                  res_st <= ST_FULL;
                  state  <= S_FINISH;
                end else begin
                  res_st <= ST_DONE;
                  ins    <= 1'b1;
                  ipos   <= ip[AW-1:0];
                  src    <= AW'(count - CW'(1));
                  left   <= count - ip;
                  state  <= S_SHIFT;
                end
              end
              REQ_DELETE: begin
                res_val <= '0;
                if (pos_in >= count) begin
                  res_st <= ST_RANGE;
                  state  <= S_FINISH;
                end else begin
                  res_st <= ST_DONE;
                  ins    <= 1'b0;
                  src    <= AW'(pos_in + CW'(1));
                  left   <= count - pos_in - CW'(1);
                  state  <= S_SHIFT;
                end
              end
              default: begin
                res_val <= '0;
                res_st  <= ST_RANGE;
                state   <= S_FINISH;
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_CAPTURE;
        end
        S_CAPTURE: begin
          res_val <= ram_rdata;
          state   <= S_FINISH;
        end
        S_SHIFT: begin
          if (left != '0) begin
            pend     <= 1'b1;
            pend_dst <= ins ? src_inc : src_dec;
            src      <= ins ? src_dec : src_inc;
            left     <= left - CW'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              if (ins) begin
                state <= S_PUT;
              end else begin
                count <= count - CW'(1);
                state <= S_FINISH;
              end
            end
          end
        end
        S_PUT: begin
          count <= count + CW'(1);
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_TW'({count, res_st, res_val});
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/ils_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/ils_check.sv @@
// Port-level checker for the indexed list store and its bind to the top level.
module ils_check #(
  parameter int DEPTH = 64,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int OUT_TW = ((ils_pkg::VAL_W + ils_pkg::ST_W + CW + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [OUT_TW-1:0] m_tdata
);

  import ils_pkg::*;

  logic [VAL_W-1:0] read_value;
  status_t          status;
  logic [CW-1:0]    entry_count;

  assign read_value  = m_tdata[VAL_W-1:0];
  assign status      = m_tdata[VAL_W+ST_W-1:VAL_W];
  assign entry_count = m_tdata[VAL_W+ST_W+CW-1:VAL_W+ST_W];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or dropped");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in progress");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status == ST_FULL |-> entry_count == CW'(DEPTH))
    else $error("store full reported below capacity");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> entry_count <= CW'(DEPTH))
    else $error("entry count beyond capacity");

  a_err_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status != ST_DONE |-> read_value == '0 || read_value == '1)
    else $error("failed request returned a data value");

endmodule

bind indexed_list_store ils_check #(.DEPTH(DEPTH)) u_ils_check (.*);

@@ tb/sv/tb_indexed_list_store.sv @@
// Self-checking testbench for the indexed list store with random stream stalls.
module tb_indexed_list_store;
  import ils_pkg::*;

  localparam int LIST_DEPTH = 64;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int IN_TW = ((REQ_W + CW + VAL_W + 7) / 8) * 8;
  localparam int OUT_TW = ((VAL_W + ST_W + CW + 7) / 8) * 8;
  localparam int ITEMS = 1250;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_MID = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_LAST = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic [CW-1:0]    pos;
    logic [VAL_W-1:0] val;
  } list_req_t;

  typedef struct packed {
    logic [VAL_W-1:0] rd;
    status_t          st;
    logic [CW-1:0]    cnt;
  } list_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_TW-1:0]  s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_TW-1:0] m_tdata;

  list_req_t    pending_reqs[$];
  list_result_t expected_results[$];
  logic [VAL_W-1:0] list_model[$];
  list_req_t    offered_req;
  int plan_len = 0;
  int item_total = 0;
  int reqs_taken = 0;
  int errors = 0;
  int peak_len = 0;
  int hold_left = 0;
  bit hold_started = 1'b0;
  int req_seen[8] = '{default: 0};
  int status_seen[4] = '{default: 0};
  int send_idle_pct[3] = '{15, 51, 0};
  int recv_idle_pct[3] = '{51, 15, 0};

  indexed_list_store #(
    .DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int stall_phase();
    if (reqs_taken * 3 < item_total) return 0;
    if (reqs_taken * 3 < item_total * 2) return 1;
    return 2;
  endfunction

  function automatic status_t place_entry(int at, logic [VAL_W-1:0] v);
    if (at > list_model.size()) return ST_RANGE;
    if (list_model.size() >= LIST_DEPTH) return ST_FULL;
    list_model.insert(at, v);
    if (list_model.size() > peak_len) peak_len = list_model.size();
    return ST_DONE;
  endfunction

  function automatic list_result_t apply_req(list_req_t rq);
    list_result_t r;
    r.rd = '0;
    case (rq.req)
      REQ_READ: begin
        if (rq.pos < list_model.size()) begin
          r.rd = list_model[rq.pos];
          r.st = ST_DONE;
        end else begin
          r.rd = '1;
          r.st = ST_RANGE;
        end
      end
      REQ_INS_FRONT: r.st = place_entry(0, rq.val);
      REQ_INS_BACK:  r.st = place_entry(list_model.size(), rq.val);
      REQ_INS_POS:   r.st = place_entry(rq.pos, rq.val);
      REQ_DELETE: begin
        if (rq.pos < list_model.size()) begin
          list_model.delete(rq.pos);
          r.st = ST_DONE;
        end else begin
          r.st = ST_RANGE;
        end
      end
      default: r.st = ST_RANGE;
    endcase
    r.cnt = CW'(list_model.size());
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CW-1:0] held_pos();
    return (plan_len > 0) ? CW'($urandom_range(plan_len - 1, 0)) : '0;
  endfunction

  function automatic logic [CW-1:0] gap_pos();
    return CW'($urandom_range(plan_len, 0));
  endfunction

  task automatic queue_req(logic [REQ_W-1:0] req, logic [CW-1:0] pos, logic [VAL_W-1:0] val);
    list_req_t rq;
    rq.req = req;
    rq.pos = pos;
    rq.val = val;
    pending_reqs.push_back(rq);
    case (req)
      REQ_INS_FRONT, REQ_INS_BACK: if (plan_len < LIST_DEPTH) plan_len++;
      REQ_INS_POS: if (pos <= plan_len && plan_len < LIST_DEPTH) plan_len++;
      REQ_DELETE: if (pos < plan_len) plan_len--;
      default: ;
    endcase
  endtask

  task automatic queue_any_insert();
    case ($urandom_range(2))
      0: queue_req(REQ_INS_FRONT, CW'($urandom), pick_value());
      1: queue_req(REQ_INS_BACK, CW'($urandom), pick_value());
      default: queue_req(REQ_INS_POS, gap_pos(), pick_value());
    endcase
  endtask

  task automatic build_stimulus();
    int seg;
    int pick;
    queue_req(REQ_READ, 7'd0, '0);
    queue_req(REQ_DELETE, 7'd0, '0);
    queue_req(REQ_INS_POS, 7'd1, 32'h1234_5678);
    queue_req(REQ_INS_POS, 7'd0, 32'h7fff_ffff);
    queue_req(REQ_INS_FRONT, 7'd127, 32'h8000_0000);
    queue_req(REQ_INS_BACK, 7'd0, 32'hffff_ffff);
    queue_req(REQ_INS_BACK, 7'd127, 32'h0000_0000);
    queue_req(REQ_INS_POS, 7'd1, 32'h5555_5555);
    queue_req(REQ_INS_POS, 7'd5, 32'haaaa_aaaa);
    queue_req(REQ_INS_POS, 7'd64, 32'h0f0f_0f0f);
    queue_req(REQ_READ, 7'd0, 32'hffff_ffff);
    queue_req(REQ_READ, 7'd4, '0);
    queue_req(REQ_READ, 7'd5, '0);
    queue_req(REQ_READ, 7'd127, '0);
    queue_req(REQ_INS_POS, 7'd127, 32'hdead_beef);
    queue_req(REQ_DELETE, 7'd127, '0);
    queue_req(REQ_SPARE_FIRST, 7'd127, 32'hffff_ffff);
    queue_req(REQ_SPARE_MID, 7'd0, 32'h0000_0001);
    queue_req(REQ_SPARE_LAST, 7'd64, 32'h8000_0000);
    queue_req(REQ_DELETE, 7'd2, '0);
    queue_req(REQ_DELETE, 7'd0, '0);
    queue_req(REQ_DELETE, 7'd2, '0);
    queue_req(REQ_READ, 7'd1, '0);

    seg = 0;
    while (pending_reqs.size() < ITEMS) begin
      case (seg % 3)
        0: begin
          while (plan_len < LIST_DEPTH) begin
            pick = $urandom_range(9);
            if (pick <= 2) queue_req(REQ_INS_FRONT, CW'($urandom), pick_value());
            else if (pick <= 5) queue_req(REQ_INS_BACK, CW'($urandom), pick_value());
            else if (pick <= 7) queue_req(REQ_INS_POS, gap_pos(), pick_value());
            else if (pick == 8) queue_req(REQ_READ, held_pos(), $urandom);
            else queue_req(REQ_DELETE, held_pos(), $urandom);
          end
          repeat ($urandom_range(4, 1)) begin
            if ($urandom_range(3) == 0) queue_req(REQ_INS_POS, CW'($urandom), pick_value());
            else queue_any_insert();
          end
          repeat ($urandom_range(6, 2)) queue_req(REQ_READ, held_pos(), $urandom);
        end
        1: begin
          while (plan_len > 0) begin
            pick = $urandom_range(9);
            if (pick <= 6) queue_req(REQ_DELETE, held_pos(), $urandom);
            else if (pick <= 8) queue_req(REQ_READ, held_pos(), $urandom);
            else queue_any_insert();
          end
          repeat ($urandom_range(2, 1)) begin
            if ($urandom_range(1) == 0) queue_req(REQ_DELETE, CW'($urandom), $urandom);
            else queue_req(REQ_READ, CW'($urandom), $urandom);
          end
        end
        default: begin
          repeat ($urandom_range(60, 20)) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
              queue_req(REQ_SPARE_LAST - REQ_W'($urandom_range(2)), CW'($urandom), $urandom);
            end else if (pick < 15) begin
              case ($urandom_range(2))
                0: queue_req(REQ_READ, CW'($urandom), $urandom);
                1: queue_req(REQ_INS_POS, CW'($urandom), pick_value());
                default: queue_req(REQ_DELETE, CW'($urandom), $urandom);
              endcase
            end else begin
              case ($urandom_range(4))
                0: queue_req(REQ_READ, held_pos(), $urandom);
                1: queue_req(REQ_INS_FRONT, CW'($urandom), pick_value());
                2: queue_req(REQ_INS_BACK, CW'($urandom), pick_value());
                3: queue_req(REQ_INS_POS, gap_pos(), pick_value());
                default: queue_req(REQ_DELETE, held_pos(), $urandom);
              endcase
            end
          end
        end
      endcase
      seg++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_req(offered_req));
        req_seen[offered_req.req]++;
        reqs_taken++;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct[stall_phase()]) begin
          offered_req = pending_reqs.pop_front();
          s_tdata <= IN_TW'({offered_req.val, offered_req.pos, offered_req.req});
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.rd = m_tdata[VAL_W-1:0];
        got.st = m_tdata[VAL_W +: ST_W];
        got.cnt = m_tdata[VAL_W + ST_W +: CW];
        status_seen[got.st]++;
        if (expected_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected, actual %h", $time, got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.rd !== want.rd) begin
            $display("%0t: read_value expected %h actual %h", $time, want.rd, got.rd);
            errors++;
          end
          if (got.st !== want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
            errors++;
          end
          if (got.cnt !== want.cnt) begin
            $display("%0t: entry_count expected %0d actual %0d", $time, want.cnt, got.cnt);
            errors++;
          end
        end
      end
      if (!hold_started && reqs_taken >= item_total * 5 / 6) begin
        hold_started = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct[stall_phase()]);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("indexed_list_store verification failed");
    $finish;
  end

  initial begin
    build_stimulus();
    item_total = pending_reqs.size();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      errors++;
    end
    $display("Sent %0d requests: %0d reads, %0d inserts, %0d deletes, %0d unused codes.",
             reqs_taken, req_seen[REQ_READ],
             req_seen[REQ_INS_FRONT] + req_seen[REQ_INS_BACK] + req_seen[REQ_INS_POS],
             req_seen[REQ_DELETE],
             req_seen[REQ_SPARE_FIRST] + req_seen[REQ_SPARE_MID] + req_seen[REQ_SPARE_LAST]);
    $display("Results: %0d done, %0d out of range, %0d refused as full; list peaked at %0d.",
             status_seen[ST_DONE], status_seen[ST_RANGE], status_seen[ST_FULL], peak_len);
    if (errors == 0) begin
      $display("indexed_list_store verification clean");
    end else begin
      $display("indexed_list_store verification failed");
    end
    $finish;
  end

endmodule
